// ===== rtl/tdd_pkg.sv =====
`timescale 1ns / 1ps

package tdd_pkg;

   // Sizes of the count store and the tab grid
   localparam int MAX_COLUMNS = 64;
   localparam int COL_AW      = $clog2(MAX_COLUMNS);
   localparam int TAB_STOP    = 8;
   localparam int TPH_W       = $clog2(TAB_STOP + 1);

   // Field widths
   localparam int CHAR_W   = 8;
   localparam int COUNT_W  = 8;
   localparam int POS_W    = 14;
   localparam int LINE_W   = 16;
   localparam int CU_W     = 7;
   localparam int HS_W     = 8;
   localparam int VS_W     = 7;
   localparam int LS_W     = 8;
   localparam int COLOUT_W = 6;
   localparam int CLASS_W  = 2;

   // Result request packing in rsp_tdata
   localparam int RSP_DATA_W = 32;
   localparam int COL_LSB    = 0;
   localparam int ROW_LSB    = COL_LSB + COLOUT_W;
   localparam int CLASS_LSB  = ROW_LSB + LINE_W;
   localparam int ALT_BIT    = CLASS_LSB + CLASS_W;
   localparam int RSP_USED_W = ALT_BIT + 1;

   // Configuration port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;

   // Character codes
   localparam logic [CHAR_W-1:0] CH_LF        = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR        = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
   localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
   localparam logic [CHAR_W-1:0] CH_PRINT_LO  = 8'h21;
   localparam logic [CHAR_W-1:0] CH_PRINT_HI  = 8'h7E;
   localparam logic [CHAR_W-1:0] CH_LATIN1_LO = 8'hA0;

   // Density thresholds in percent, and the saturation ceiling
   localparam int PCT_LOW  = 15;
   localparam int PCT_MID  = 40;
   localparam int PCT_HIGH = 70;
   localparam int PCT_UNIT = 100;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

   // Density classes
   typedef enum logic [CLASS_W-1:0] {
      CLS_SPARSE = 2'd0,
      CLS_LOW    = 2'd1,
      CLS_MEDIUM = 2'd2,
      CLS_HIGH   = 2'd3
   } density_type;

   // Register indexes (byte address / 4)
   typedef enum logic [2:0] {
      CSR_COLUMNS    = 3'd0,
      CSR_HSCALE     = 3'd1,
      CSR_VSCALE     = 3'd2,
      CSR_LINE_CHARS = 3'd3,
      CSR_MAX_LINES  = 3'd4,
      CSR_LINE_STEP  = 3'd5
   } csr_index_type;

endpackage

// ===== rtl/tdd_ram.sv =====
`timescale 1ns / 1ps

module tdd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port, and a registered read that holds while not enabled
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/text_density_downscaler_top.sv =====
`timescale 1ns / 1ps

// Text density downscaler. Each request carries one text byte (req_tdata) or, with
// req_tuser set, an end-of-text mark. Per-column saturating counts live in a 64-entry
// synchronous RAM and are updated by read-modify-write (ST_RMW_RD, then ST_RMW_WR) per
// character position. An ordinary byte passes dispatch and a read-modify-write; CR and
// bytes past the line width or line limit pass dispatch only; a tab passes one per
// position it spans. A flush (line feed closing a block, line limit, or end of text)
// reads each column in use (ST_FL_RD, then ST_FL_EV), ends in ST_FL_END, and can stall
// on the result side. After a register write the next request passes a shared
// bit-serial divider that rebuilds the column and row positions from the character
// and line counters. No clearing pass follows reset: per-entry valid bits stand in for
// the zeroed counts. Results leave through an output register, one per column with a
// nonzero count, with rsp_tlast on the last of each flush.
module text_density_downscaler_top
   import tdd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Input requests
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] char_byte
   input  logic                  req_tuser,   // [0] end_of_text
   // Result requests
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [5:0] column, [21:6] row_y,
                                              // [23:22] density_class, [24] alternate_row
   output logic                  rsp_tlast,   // last
   // Configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV_CP,
      ST_DIV_LC,
      ST_DISPATCH,
      ST_RMW_RD,
      ST_RMW_WR,
      ST_FL_RD,
      ST_FL_EV,
      ST_FL_END
   } state_type;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_INC,
      OP_DEC
   } op_type;

   localparam int DIV_W   = 16;
   localparam int DIVC_W  = $clog2(DIV_W);
   localparam int REM_W   = HS_W + 1;
   localparam int P_W     = HS_W + VS_W;
   localparam int THR_W   = P_W + 7;
   localparam int C100_W  = COUNT_W + 7;
   localparam int SCAN_W  = COL_AW + 1;

   // Configuration registers
   logic [CU_W-1:0]   cu_ff;
   logic [HS_W-1:0]   hs_ff;
   logic [VS_W-1:0]   vs_ff;
   logic [POS_W-1:0]  lc_ff;
   logic [LINE_W-1:0] ml_ff;
   logic [LS_W-1:0]   ls_ff;
   logic              csr_write;
   csr_index_type     csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_index_type'(csr_paddr[4:2]);

   // Take register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cu_ff <= CU_W'(MAX_COLUMNS);
         hs_ff <= 8'd2;
         vs_ff <= 7'd1;
         lc_ff <= 14'd128;
         ml_ff <= 16'd32;
         ls_ff <= 8'd1;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_COLUMNS:    cu_ff <= csr_pwdata[CU_W-1:0];
            CSR_HSCALE:     hs_ff <= csr_pwdata[HS_W-1:0];
            CSR_VSCALE:     vs_ff <= csr_pwdata[VS_W-1:0];
            CSR_LINE_CHARS: lc_ff <= csr_pwdata[POS_W-1:0];
            CSR_MAX_LINES:  ml_ff <= csr_pwdata[LINE_W-1:0];
            CSR_LINE_STEP:  ls_ff <= csr_pwdata[LS_W-1:0];
            default: ;
         endcase
      end
   end

   // Read back registers
   always_comb begin
      csr_prdata = '0;
      unique case (csr_index)
         CSR_COLUMNS:    csr_prdata = CSR_DATA_W'(cu_ff);
         CSR_HSCALE:     csr_prdata = CSR_DATA_W'(hs_ff);
         CSR_VSCALE:     csr_prdata = CSR_DATA_W'(vs_ff);
         CSR_LINE_CHARS: csr_prdata = CSR_DATA_W'(lc_ff);
         CSR_MAX_LINES:  csr_prdata = CSR_DATA_W'(ml_ff);
         CSR_LINE_STEP:  csr_prdata = CSR_DATA_W'(ls_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // Effective settings: zero acts as one for the scales and limits, columns capped
   logic [HS_W-1:0]   hs_eff;
   logic [VS_W-1:0]   vs_eff;
   logic [POS_W-1:0]  lc_eff;
   logic [LINE_W-1:0] ml_eff;
   logic [LS_W-1:0]   ls_eff;
   logic [CU_W-1:0]   cols_eff;

   assign hs_eff   = (hs_ff == '0) ? HS_W'(1) : hs_ff;
   assign vs_eff   = (vs_ff == '0) ? VS_W'(1) : vs_ff;
   assign lc_eff   = (lc_ff == '0) ? POS_W'(1) : lc_ff;
   assign ml_eff   = (ml_ff == '0) ? LINE_W'(1) : ml_ff;
   assign ls_eff   = (ls_ff == '0) ? LS_W'(1) : ls_ff;
   assign cols_eff = (cu_ff > CU_W'(MAX_COLUMNS)) ? CU_W'(MAX_COLUMNS) : cu_ff;

   // Control and datapath registers
   state_type           state_ff, state_in;
   op_type              op_ff, op_in;
   logic                dirty_ff, dirty_in;
   logic [CHAR_W-1:0]   ch_ff, ch_in;
   logic                end_ff, end_in;
   logic [POS_W-1:0]    cp_ff, cp_in;
   logic [POS_W-1:0]    col_ff, col_in;
   logic [HS_W-1:0]     sub_ff, sub_in;
   logic [TPH_W-1:0]    tph_ff, tph_in;
   logic [POS_W-1:0]    stop_ff, stop_in;
   logic [LINE_W-1:0]   line_ff, line_in;
   logic [LINE_W-1:0]   row_ff, row_in;
   logic [VS_W-1:0]     lsub_ff, lsub_in;
   logic [MAX_COLUMNS-1:0] valid_ff, valid_in;
   logic [DIVC_W-1:0]   dcnt_ff, dcnt_in;
   logic [REM_W-1:0]    drem_ff, drem_in;
   logic [DIV_W-1:0]    dquo_ff, dquo_in;
   logic [SCAN_W-1:0]   scan_ff, scan_in;
   logic [LINE_W-1:0]   y_ff, y_in;
   logic                pend_ff, pend_in;
   logic [COLOUT_W-1:0] pcol_ff, pcol_in;
   density_type         pcls_ff, pcls_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [COLOUT_W-1:0] rsp_col_ff, rsp_col_in;
   logic [LINE_W-1:0]   rsp_row_ff, rsp_row_in;
   density_type         rsp_cls_ff, rsp_cls_in;
   logic                rsp_last_ff, rsp_last_in;
   logic [P_W-1:0]      p_ff;
   logic [THR_W-1:0]    t15_ff, t40_ff, t70_ff;

   // Count store
   logic                ram_we;
   logic [COL_AW-1:0]   ram_waddr;
   logic [COUNT_W-1:0]  ram_wdata;
   logic                ram_re;
   logic [COL_AW-1:0]   ram_raddr;
   logic [COUNT_W-1:0]  ram_q;

   tdd_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (MAX_COLUMNS)
   ) u_counts (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_q)
   );

   // Divider step shared by the position and line recomputes
   logic [REM_W-1:0] div_shift;
   logic [REM_W-1:0] div_divisor;
   logic             div_bit;
   logic [REM_W-1:0] div_rem_next;
   logic [DIV_W-1:0] div_quo_next;

   assign div_divisor  = (state_ff == ST_DIV_CP) ? REM_W'(hs_eff) : REM_W'(vs_eff);
   assign div_shift    = {drem_ff[REM_W-2:0], dquo_ff[DIV_W-1]};
   assign div_bit      = (div_shift >= div_divisor);
   assign div_rem_next = div_bit ? (div_shift - div_divisor) : div_shift;
   assign div_quo_next = {dquo_ff[DIV_W-2:0], div_bit};

   // Character decode
   logic printable;
   assign printable = ((ch_ff >= CH_PRINT_LO) && (ch_ff <= CH_PRINT_HI)) ||
                      (ch_ff >= CH_LATIN1_LO);

   // Tab stop, capped at the line width
   logic [TPH_W-1:0] tab_room;
   logic [POS_W:0]   tab_next;
   logic [POS_W-1:0] tab_stop;
   assign tab_room = TPH_W'(TAB_STOP) - tph_ff;
   assign tab_next = {1'b0, cp_ff} + (POS_W+1)'(tab_room);
   assign tab_stop = (tab_next > {1'b0, lc_eff}) ? lc_eff : tab_next[POS_W-1:0];

   // Counter stepping
   logic [LINE_W-1:0] line_inc;
   logic              lsub_wrap;
   logic [POS_W-1:0]  cp_inc;
   logic              in_range;
   logic [LINE_W+LS_W-1:0] y_prod;
   assign line_inc  = line_ff + LINE_W'(1);
   assign lsub_wrap = ((lsub_ff + VS_W'(1)) == vs_eff);
   assign cp_inc    = cp_ff + POS_W'(1);
   assign in_range  = (col_ff < POS_W'(cols_eff));
   assign y_prod    = row_ff * ls_eff;

   // Stored count, zero where never written since the last clear
   logic [COL_AW-1:0]  rd_index;
   logic [COUNT_W-1:0] cur_val;
   logic [COUNT_W-1:0] mod_val;
   assign rd_index = (state_ff == ST_RMW_WR) ? col_ff[COL_AW-1:0] : scan_ff[COL_AW-1:0];
   assign cur_val  = valid_ff[rd_index] ? ram_q : '0;

   always_comb begin
      mod_val = cur_val;
      case (op_ff)
         OP_INC:  mod_val = (cur_val == COUNT_MAX) ? cur_val : cur_val + COUNT_W'(1);
         OP_DEC:  mod_val = (cur_val == '0) ? cur_val : cur_val - COUNT_W'(1);
         default: mod_val = cur_val;
      endcase
   end

   // Density class against thresholds scaled by hscale * vscale
   logic [C100_W-1:0] cnt100;
   density_type       cls_now;
   assign cnt100 = C100_W'(cur_val) * C100_W'(PCT_UNIT);

   always_comb begin
      if ((cur_val == COUNT_W'(1)) || (THR_W'(cnt100) < t15_ff)) begin
         cls_now = CLS_SPARSE;
      end else if (THR_W'(cnt100) < t40_ff) begin
         cls_now = CLS_LOW;
      end else if (THR_W'(cnt100) < t70_ff) begin
         cls_now = CLS_MEDIUM;
      end else begin
         cls_now = CLS_HIGH;
      end
   end

   logic out_free;
   assign out_free = !rsp_valid_ff || rsp_tready;

   // Next state
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      dirty_in     = dirty_ff;
      ch_in        = ch_ff;
      end_in       = end_ff;
      cp_in        = cp_ff;
      col_in       = col_ff;
      sub_in       = sub_ff;
      tph_in       = tph_ff;
      stop_in      = stop_ff;
      line_in      = line_ff;
      row_in       = row_ff;
      lsub_in      = lsub_ff;
      valid_in     = valid_ff;
      dcnt_in      = dcnt_ff;
      drem_in      = drem_ff;
      dquo_in      = dquo_ff;
      scan_in      = scan_ff;
      y_in         = y_ff;
      pend_in      = pend_ff;
      pcol_in      = pcol_ff;
      pcls_in      = pcls_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_cls_in   = rsp_cls_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;
      ram_we       = 1'b0;
      ram_waddr    = col_ff[COL_AW-1:0];
      ram_wdata    = mod_val;
      ram_re       = 1'b0;
      ram_raddr    = col_ff[COL_AW-1:0];
      req_tready   = 1'b0;

      unique case (state_ff)
         // Take a request; rebuild positions first after a register write
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               ch_in  = req_tdata;
               end_in = req_tuser;
               if (dirty_ff) begin
                  dquo_in  = DIV_W'(cp_ff);
                  drem_in  = '0;
                  dcnt_in  = '0;
                  state_in = ST_DIV_CP;
               end else begin
                  state_in = ST_DISPATCH;
               end
            end
         end

         // Column and offset within it from the character position
         ST_DIV_CP: begin
            dquo_in = div_quo_next;
            drem_in = div_rem_next;
            dcnt_in = dcnt_ff + DIVC_W'(1);
            if (dcnt_ff == DIVC_W'(DIV_W - 1)) begin
               col_in   = div_quo_next[POS_W-1:0];
               sub_in   = div_rem_next[HS_W-1:0];
               dquo_in  = line_ff;
               drem_in  = '0;
               dcnt_in  = '0;
               state_in = ST_DIV_LC;
            end
         end

         // Row and line within it from the line count
         ST_DIV_LC: begin
            dquo_in = div_quo_next;
            drem_in = div_rem_next;
            dcnt_in = dcnt_ff + DIVC_W'(1);
            if (dcnt_ff == DIVC_W'(DIV_W - 1)) begin
               row_in   = div_quo_next;
               lsub_in  = div_rem_next[VS_W-1:0];
               dirty_in = 1'b0;
               state_in = ST_DISPATCH;
            end
         end

         // Decide what the request does
         ST_DISPATCH: begin
            scan_in  = '0;
            y_in     = y_prod[LINE_W-1:0];
            state_in = ST_IDLE;
            if (end_ff) begin
               if ((line_ff < ml_eff) && (lsub_ff != '0)) begin
                  state_in = (cols_eff == '0) ? ST_FL_END : ST_FL_RD;
               end else begin
                  valid_in = '0;
                  cp_in    = '0;
                  col_in   = '0;
                  sub_in   = '0;
                  tph_in   = '0;
                  line_in  = '0;
                  row_in   = '0;
                  lsub_in  = '0;
               end
            end else if (line_ff >= ml_eff) begin
               state_in = ST_IDLE;
            end else if (ch_ff == CH_LF) begin
               line_in = line_inc;
               cp_in   = '0;
               col_in  = '0;
               sub_in  = '0;
               tph_in  = '0;
               if (lsub_wrap) begin
                  lsub_in = '0;
                  row_in  = row_ff + LINE_W'(1);
               end else begin
                  lsub_in = lsub_ff + VS_W'(1);
               end
               if (lsub_wrap || (line_inc >= ml_eff)) begin
                  state_in = (cols_eff == '0) ? ST_FL_END : ST_FL_RD;
               end
            end else if (ch_ff == CH_CR) begin
               state_in = ST_IDLE;
            end else if (ch_ff == CH_TAB) begin
               if (cp_ff < tab_stop) begin
                  stop_in  = tab_stop;
                  op_in    = OP_DEC;
                  state_in = ST_RMW_RD;
               end
            end else if (cp_ff < lc_eff) begin
               stop_in = cp_inc;
               if (printable) begin
                  op_in = OP_INC;
               end else if (ch_ff == CH_SPACE) begin
                  op_in = OP_DEC;
               end else begin
                  op_in = OP_NONE;
               end
               state_in = ST_RMW_RD;
            end
         end

         // Fetch the count of the current column
         ST_RMW_RD: begin
            ram_re   = 1'b1;
            state_in = ST_RMW_WR;
         end

         // Write back the updated count and advance one position
         ST_RMW_WR: begin
            if (in_range && (op_ff != OP_NONE)) begin
               ram_we                       = 1'b1;
               valid_in[col_ff[COL_AW-1:0]] = 1'b1;
            end
            cp_in  = cp_inc;
            tph_in = ((tph_ff + TPH_W'(1)) == TPH_W'(TAB_STOP)) ? '0 : tph_ff + TPH_W'(1);
            if ((sub_ff + HS_W'(1)) == hs_eff) begin
               sub_in = '0;
               col_in = col_ff + POS_W'(1);
            end else begin
               sub_in = sub_ff + HS_W'(1);
            end
            state_in = (cp_inc < stop_ff) ? ST_RMW_RD : ST_IDLE;
         end

         // Scan the columns in use
         ST_FL_RD: begin
            ram_re    = 1'b1;
            ram_raddr = scan_ff[COL_AW-1:0];
            state_in  = ST_FL_EV;
         end

         // Hold one result back so the last of the flush can be marked
         ST_FL_EV: begin
            if ((cur_val == '0) || !pend_ff || out_free) begin
               if (cur_val != '0) begin
                  if (pend_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_col_in   = pcol_ff;
                     rsp_cls_in   = pcls_ff;
                     rsp_row_in   = y_ff;
                     rsp_last_in  = 1'b0;
                  end
                  pend_in = 1'b1;
                  pcol_in = scan_ff[COLOUT_W-1:0];
                  pcls_in = cls_now;
               end
               scan_in  = scan_ff + SCAN_W'(1);
               state_in = ((scan_ff + SCAN_W'(1)) < SCAN_W'(cols_eff)) ? ST_FL_RD : ST_FL_END;
            end
         end

         // Send the held result as last, drop the counts
         ST_FL_END: begin
            if (!pend_ff || out_free) begin
               if (pend_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_col_in   = pcol_ff;
                  rsp_cls_in   = pcls_ff;
                  rsp_row_in   = y_ff;
                  rsp_last_in  = 1'b1;
                  pend_in      = 1'b0;
               end
               valid_in = '0;
               if (end_ff) begin
                  cp_in   = '0;
                  col_in  = '0;
                  sub_in  = '0;
                  tph_in  = '0;
                  line_in = '0;
                  row_in  = '0;
                  lsub_in = '0;
               end
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase

      if (csr_write) begin
         dirty_in = 1'b1;
      end
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dirty_ff     <= 1'b0;
         cp_ff        <= '0;
         col_ff       <= '0;
         sub_ff       <= '0;
         tph_ff       <= '0;
         line_ff      <= '0;
         row_ff       <= '0;
         lsub_ff      <= '0;
         valid_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dirty_ff     <= dirty_in;
         cp_ff        <= cp_in;
         col_ff       <= col_in;
         sub_ff       <= sub_in;
         tph_ff       <= tph_in;
         line_ff      <= line_in;
         row_ff       <= row_in;
         lsub_ff      <= lsub_in;
         valid_ff     <= valid_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      ch_ff       <= ch_in;
      end_ff      <= end_in;
      stop_ff     <= stop_in;
      dcnt_ff     <= dcnt_in;
      drem_ff     <= drem_in;
      dquo_ff     <= dquo_in;
      scan_ff     <= scan_in;
      y_ff        <= y_in;
      pcol_ff     <= pcol_in;
      pcls_ff     <= pcls_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_cls_ff  <= rsp_cls_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Keep the class thresholds in step with the scales
   always_ff @(posedge clock) begin
      p_ff   <= hs_eff * vs_eff;
      t15_ff <= THR_W'(p_ff) * THR_W'(PCT_LOW);
      t40_ff <= THR_W'(p_ff) * THR_W'(PCT_MID);
      t70_ff <= THR_W'(p_ff) * THR_W'(PCT_HIGH);
   end

   // Drive the result port
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {(RSP_DATA_W - RSP_USED_W)'(0), rsp_row_ff[0], rsp_cls_ff,
                        rsp_row_ff, rsp_col_ff};

endmodule

// ===== rtl/tdd_checker.sv =====
`timescale 1ns / 1ps

module tdd_checker
   import tdd_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tlast,
   input logic                  csr_pready
);

   // A stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result request changed");

   // The odd-row flag follows the row position
   a_alt_row: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[ALT_BIT] == rsp_tdata[ROW_LSB]))
      else $error("alternate_row does not match row_y");

   // An accepted request is worked on before the next is taken
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while previous still in work");

   // The configuration port never waits
   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("configuration port not ready");

endmodule

bind text_density_downscaler_top tdd_checker u_tdd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .csr_pready (csr_pready)
);

// ===== test/tb_text_density_downscaler_top.sv =====
`timescale 1ns / 1ps

module tb_text_density_downscaler_top;
   import tdd_pkg::*;

   localparam int SETTLE_CYCLES  = 200;
   localparam int HOLD_CYCLES    = 600;
   localparam int WATCHDOG_LIMIT = 5000;

   // One painted column as it should leave the block
   typedef struct {
      logic [COLOUT_W-1:0] column;
      logic [LINE_W-1:0]   row_y;
      density_type         density;
      logic                alternate;
      logic                last;
   } density_mark_type;

   // Density map predictor and store of the marks still to come
   class density_scoreboard_type;
      logic [CU_W-1:0]    columns_in_use;
      logic [HS_W-1:0]    hscale;
      logic [VS_W-1:0]    vscale;
      logic [POS_W-1:0]   line_chars;
      logic [LINE_W-1:0]  max_lines;
      logic [LS_W-1:0]    row_pitch;
      logic [COUNT_W-1:0] counts [MAX_COLUMNS];
      int unsigned        cursor;
      int unsigned        line_count;
      density_mark_type   expected_marks [$];
      int                 errors;

      function new();
         columns_in_use = 7'd64;
         hscale         = 8'd2;
         vscale         = 7'd1;
         line_chars     = 14'd128;
         max_lines      = 16'd32;
         row_pitch      = 8'd1;
         errors         = 0;
         clear_text();
      endfunction

      function void clear_text();
         foreach (counts[i]) counts[i] = '0;
         cursor     = 0;
         line_count = 0;
      endfunction

      function int unsigned one_if_zero(int unsigned v);
         return (v == 0) ? 1 : v;
      endfunction

      function int unsigned active_columns();
         return (columns_in_use > MAX_COLUMNS) ? MAX_COLUMNS : columns_in_use;
      endfunction

      function void write_register(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_COLUMNS:    columns_in_use = value[CU_W-1:0];
            CSR_HSCALE:     hscale         = value[HS_W-1:0];
            CSR_VSCALE:     vscale         = value[VS_W-1:0];
            CSR_LINE_CHARS: line_chars     = value[POS_W-1:0];
            CSR_MAX_LINES:  max_lines      = value[LINE_W-1:0];
            CSR_LINE_STEP:  row_pitch      = value[LS_W-1:0];
            default: ;
         endcase
      endfunction

      // Grade every nonzero column into a mark, then clear the counts
      function void emit_row(int unsigned row);
         int unsigned      area;
         int unsigned      y;
         int unsigned      pct;
         density_mark_type mark;
         density_mark_type row_marks [$];
         area = one_if_zero(hscale) * one_if_zero(vscale);
         y    = (row * one_if_zero(row_pitch)) & 16'hFFFF;
         for (int c = 0; c < active_columns(); c++) begin
            if (counts[c] != 0) begin
               pct            = (counts[c] * PCT_UNIT) / area;
               mark.column    = c[COLOUT_W-1:0];
               mark.row_y     = y[LINE_W-1:0];
               mark.alternate = y[0];
               mark.last      = 1'b0;
               if (counts[c] == 1 || pct < PCT_LOW) mark.density = CLS_SPARSE;
               else if (pct < PCT_MID)              mark.density = CLS_LOW;
               else if (pct < PCT_HIGH)             mark.density = CLS_MEDIUM;
               else                                 mark.density = CLS_HIGH;
               row_marks.push_back(mark);
            end
         end
         if (row_marks.size() > 0) row_marks[row_marks.size()-1].last = 1'b1;
         foreach (row_marks[i]) expected_marks.push_back(row_marks[i]);
         foreach (counts[i]) counts[i] = '0;
      endfunction

      // Fold one accepted request into the map
      function void note_request(logic [CHAR_W-1:0] ch, logic end_mark);
         int unsigned vs;
         int unsigned hs;
         int unsigned lc;
         int unsigned ml;
         int unsigned next_stop;
         int unsigned x;
         vs = one_if_zero(vscale);
         hs = one_if_zero(hscale);
         lc = one_if_zero(line_chars);
         ml = one_if_zero(max_lines);
         if (end_mark) begin
            if (line_count < ml && (line_count % vs) != 0) emit_row(line_count / vs);
            clear_text();
            return;
         end
         if (line_count >= ml) return;
         if (ch == CH_LF) begin
            line_count = (line_count + 1) & 16'hFFFF;
            if ((line_count % vs) == 0 || line_count >= ml) emit_row((line_count - 1) / vs);
            cursor = 0;
            return;
         end
         if (ch == CH_CR) return;
         if (ch == CH_TAB) begin
            next_stop = ((cursor / TAB_STOP) + 1) * TAB_STOP;
            if (next_stop > lc) next_stop = lc;
            while (cursor < next_stop) begin
               x = cursor / hs;
               if (x < active_columns() && counts[x] > 0) counts[x]--;
               cursor++;
            end
            return;
         end
         if (cursor >= lc) return;
         x = cursor / hs;
         if (x < active_columns()) begin
            if ((ch >= CH_PRINT_LO && ch <= CH_PRINT_HI) || ch >= CH_LATIN1_LO) begin
               if (counts[x] < COUNT_MAX) counts[x]++;
            end else if (ch == CH_SPACE) begin
               if (counts[x] > 0) counts[x]--;
            end
         end
         cursor++;
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      // Match one accepted result against the oldest mark
      function void check_result(logic [RSP_DATA_W-1:0] data, logic tlast);
         density_mark_type want;
         if (expected_marks.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual column %0d row %0d",
                     $time, data[COL_LSB +: COLOUT_W], data[ROW_LSB +: LINE_W]);
            errors++;
            return;
         end
         want = expected_marks.pop_front();
         compare_field("column", want.column, data[COL_LSB +: COLOUT_W]);
         compare_field("row_y", want.row_y, data[ROW_LSB +: LINE_W]);
         compare_field("density_class", want.density, data[CLASS_LSB +: CLASS_W]);
         compare_field("alternate_row", want.alternate, data[ALT_BIT]);
         compare_field("last", want.last, tlast);
      endfunction

      function int pending();
         return expected_marks.size();
      endfunction
   endclass

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata   = '0;
   logic                  req_tuser   = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   density_scoreboard_type scoreboard;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_requests  = 0;
   int hold_served    = 0;
   int hold_left      = 0;
   int idle_cycles    = 0;
   int requests_sent  = 0;
   int line_len       = 16;

   text_density_downscaler_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Check results; stall at random, or hold off for a long stretch on request
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) scoreboard.check_result(rsp_tdata, rsp_tlast);
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // End the run when nothing has moved for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pwrite && csr_pready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Offer one request and hold it until accepted
   task automatic send_request(input logic [7:0] byte_value, input logic end_mark);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= byte_value;
      req_tuser  <= end_mark;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      scoreboard.note_request(byte_value, end_mark);
      requests_sent++;
   endtask

   // Stop offering and wait for every mark, then let the block go quiet
   task automatic settle();
      req_tvalid <= 1'b0;
      while (scoreboard.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      scoreboard.write_register(idx, value);
   endtask

   task automatic configure(input int cols, input int hs, input int vs, input int lc,
                            input int ml, input int ls);
      settle();
      write_register(CSR_COLUMNS, cols);
      write_register(CSR_HSCALE, hs);
      write_register(CSR_VSCALE, vs);
      write_register(CSR_LINE_CHARS, lc);
      write_register(CSR_MAX_LINES, ml);
      write_register(CSR_LINE_STEP, ls);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      line_len = (lc + 4 > 16) ? 16 : lc + 4;
   endtask

   // Mostly printable text with spaces, tabs and the odd control byte
   function automatic logic [7:0] pick_text_byte();
      int r;
      r = $urandom_range(99);
      if (r < 55)      return 8'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
      else if (r < 62) return 8'($urandom_range(CH_LATIN1_LO, 255));
      else if (r < 77) return CH_SPACE;
      else if (r < 83) return CH_TAB;
      else if (r < 86) return CH_CR;
      else if (r < 91) return 8'($urandom_range(0, 31));
      else if (r < 95) return 8'($urandom_range(8'h7F, 8'h9F));
      else             return 8'($urandom);
   endfunction

   // Send lines of text closed by an end mark, sometimes cut off mid-line
   task automatic send_document(input int lines);
      int len;
      for (int l = 0; l < lines; l++) begin
         len = $urandom_range(0, line_len);
         for (int i = 0; i < len; i++) send_request(pick_text_byte(), 1'b0);
         if ($urandom_range(9) == 0) begin
            send_request(8'($urandom), 1'b1);
            return;
         end
         send_request(CH_LF, 1'b0);
      end
      send_request(8'($urandom), 1'b1);
   endtask

   task automatic run_random(input int items);
      int start;
      int count;
      start = requests_sent;
      while (requests_sent - start < items) begin
         if ($urandom_range(9) == 0) begin
            count = $urandom_range(3, 10);
            for (int i = 0; i < count; i++)
               send_request(8'($urandom), $urandom_range(19) == 0);
         end else begin
            send_document($urandom_range(1, 3));
         end
      end
   endtask

   initial begin
      int unsigned rc;
      int unsigned rh;
      scoreboard = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Field extremes and every byte class under the reset settings
      send_request(CH_SPACE, 1'b0);      // floor at zero
      send_request(8'h41, 1'b0);
      send_request(CH_PRINT_LO, 1'b0);
      send_request(CH_PRINT_HI, 1'b0);
      send_request(CH_LATIN1_LO, 1'b0);
      send_request(8'hFF, 1'b0);
      send_request(8'h00, 1'b0);
      send_request(8'h7F, 1'b0);
      send_request(8'h9F, 1'b0);
      send_request(CH_CR, 1'b0);
      send_request(CH_TAB, 1'b0);
      send_request(8'h41, 1'b0);
      send_request(CH_LF, 1'b0);

      // Narrow line: width drop, capped tab, unused columns, line limit, partial flush
      configure(3, 1, 2, 5, 3, 255);
      send_request(8'h61, 1'b0);
      send_request(8'h62, 1'b0);
      send_request(8'h63, 1'b0);
      send_request(8'h64, 1'b0);
      send_request(8'h65, 1'b0);
      send_request(8'h66, 1'b0);
      send_request(CH_TAB, 1'b0);
      send_request(CH_LF, 1'b0);
      send_request(CH_TAB, 1'b0);
      send_request(CH_LF, 1'b0);
      send_request(8'h67, 1'b0);
      send_request(CH_LF, 1'b0);
      send_request(8'h68, 1'b0);
      send_request(8'h00, 1'b1);
      send_request(8'h70, 1'b0);
      send_request(CH_LF, 1'b0);
      send_request(8'h71, 1'b0);
      send_request(8'hFF, 1'b1);

      // Saturate one wide column, then take a little back with spaces
      configure(1, 255, 2, 255, 65535, 3);
      for (int l = 0; l < 2; l++) begin
         for (int i = 0; i < 129; i++)
            send_request(8'($urandom_range(CH_PRINT_LO, CH_PRINT_HI)), 1'b0);
         if (l == 1) repeat (3) send_request(CH_SPACE, 1'b0);
         send_request(CH_LF, 1'b0);
      end
      send_request(8'h00, 1'b1);

      // Full rate; a long receiver hold-off fills the block, then a full pause
      configure(64, 1, 1, 64, 65535, 1);
      hold_requests++;
      for (int l = 0; l < 3; l++) begin
         repeat (8) send_request(8'h41, 1'b0);
         send_request(CH_LF, 1'b0);
      end
      settle();

      send_idle_pct  = 61;
      recv_stall_pct = 0;
      configure(8, 3, 2, 24, 6, 16);
      run_random(12);

      send_idle_pct  = 0;
      recv_stall_pct = 61;
      configure(1, 255, 127, 16320, 65535, 255);
      run_random(12);

      send_idle_pct  = 32;
      recv_stall_pct = 32;
      rc = $urandom_range(1, 64);
      rh = $urandom_range(1, 8);
      configure(rc, rh, $urandom_range(1, 4), $urandom_range(1, rc * rh),
                $urandom_range(1, 20), $urandom_range(1, 255));
      run_random(12);

      // Zero registers act as one and an oversized column count as the maximum
      configure(127, 0, 0, 0, 0, 0);
      run_random(5);

      // No column in use: nothing is ever painted
      configure(0, 2, 1, 1, 1, 1);
      run_random(5);

      settle();
      if (scoreboard.errors == 0 && scoreboard.pending() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/tdd_pkg.sv
rtl/tdd_ram.sv
rtl/text_density_downscaler_top.sv
rtl/tdd_checker.sv
test/tb_text_density_downscaler_top.sv
